>>> hdl/kmp_first_match_finder_defines.svh
// Assertion macros for the KMP first-match finder.
// Included by the top level; no other dependencies.
`ifndef KMP_FIRST_MATCH_FINDER_DEFINES_SVH
`define KMP_FIRST_MATCH_FINDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KMP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KMP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define KMP_ASSERT(name, prop, msg)
`define KMP_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

>>> hdl/kmp_pkg.sv
// Package for the KMP first-match finder: sizes, status codes, result type.
// No dependencies.
package kmp_pkg;

  localparam int PATTERN_MAX = 256;
  localparam int TEXT_MAX    = 65536;

  localparam int PAT_AW  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W   = $clog2(TEXT_MAX + 1);
  localparam int POS_W   = 16;
  localparam int ARITH_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    ST_READY     = 3'd0,
    ST_PAT_LONG  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NONE      = 3'd3,
    ST_TEXT_LONG = 3'd4
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [POS_W-1:0]       position;
  } kmp_res_t;

endpackage

>>> hdl/kmp_out_stage.sv
// Output register for result items, loaded while the consumer may still stall.
// Depends on kmp_pkg.
module kmp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  kmp_pkg::kmp_res_t res_i,
  input  logic              stall_i,
  output logic              valid_o,
  output kmp_pkg::kmp_res_t res_o,
  output logic              free_o
);
  import kmp_pkg::*;

  logic     valid_q, valid_d;
  kmp_res_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i ? 1'b1 : (stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hdl/kmp_first_match_finder.sv
// KMP first-match finder, top level: pattern and failure memories, sequencer.
// Depends on kmp_pkg, kmp_out_stage and kmp_first_match_finder_defines.svh.
//
//   channel  handshake               payload
//   input    in_valid_i / in_stall_o operation_i, symbol_i, last_i
//   output   out_valid_o / out_stall_i status_o, position_o
//
// A pattern byte is written to the pattern memory. While searching, a text byte is
// compared in S_TCMP, following failure links; the pattern and failure memories are
// read together, one step per cycle. The last pattern byte starts the failure build
// unless the pattern overflowed. Reset clears control only; the memories are never cleared.
// A result waits in the output register; a second result stalls the input until taken.
`include "kmp_first_match_finder_defines.svh"
module kmp_first_match_finder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [7:0]                symbol_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                status_o,
  output logic [kmp_pkg::POS_W-1:0] position_o
);
  import kmp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BINIT = 6'b000010,
    S_BLOAD = 6'b000100,
    S_BCMP  = 6'b001000,
    S_TCMP  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               ovf_q, ovf_d;
  logic               load_q, load_d;
  logic [LEN_W-1:0]   matched_q, matched_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [LEN_W-1:0]   i_q, i_d;
  logic [LEN_W-1:0]   k_q, k_d;
  logic [7:0]         byte_q, byte_d;
  logic [7:0]         sym_q, sym_d;
  logic               last_q, last_d;
  kmp_res_t           pend_q, pend_d;

  logic [7:0]         pat_mem [PATTERN_MAX];
  logic [PAT_AW-1:0]  fail_mem [PATTERN_MAX];
  logic               pat_we, fail_we;
  logic [PAT_AW-1:0]  pat_waddr, pat_raddr, fail_waddr, fail_raddr;
  logic [7:0]         pat_rdata_q;
  logic [PAT_AW-1:0]  fail_wdata, fail_rdata_q;

  logic               in_acc;
  logic [LEN_W-1:0]   pl_base_len;
  logic               pl_base_ovf, pl_fits, pl_ovf;
  logic               b_hit, t_hit;
  logic [LEN_W-1:0]   b_knext, i_inc, t_jnext;
  logic [ARITH_W-1:0] pos_found, pos_empty;

  logic               emit_v, out_load, out_free;
  kmp_res_t           emit_res, out_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pl_base_len = load_q ? len_q : '0;
  assign pl_base_ovf = load_q && ovf_q;
  assign pl_fits     = pl_base_len < LEN_W'(PATTERN_MAX);
  assign pl_ovf      = pl_base_ovf || !pl_fits;

  assign b_hit   = (byte_q == pat_rdata_q);
  assign b_knext = b_hit ? (k_q + LEN_W'(1)) : '0;
  assign i_inc   = i_q + LEN_W'(1);
  assign t_hit   = (sym_q == pat_rdata_q);
  assign t_jnext = t_hit ? (matched_q + LEN_W'(1)) : '0;

  assign pos_found = ARITH_W'(cnt_q) + ARITH_W'(1) - ARITH_W'(len_q);
  assign pos_empty = ARITH_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= symbol_i;
    end
    pat_rdata_q <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rdata_q <= fail_mem[fail_raddr];
  end

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    load_d     = load_q;
    matched_d  = matched_q;
    cnt_d      = cnt_q;
    done_d     = done_q;
    i_d        = i_q;
    k_d        = k_q;
    byte_d     = byte_q;
    sym_d      = sym_q;
    last_d     = last_q;
    pend_d     = pend_q;
    pat_we     = 1'b0;
    pat_waddr  = pl_base_len[PAT_AW-1:0];
    pat_raddr  = '0;
    fail_we    = 1'b0;
    fail_waddr = '0;
    fail_wdata = '0;
    fail_raddr = '0;
    emit_v     = 1'b0;
    emit_res.status   = ST_READY;
    emit_res.position = '0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!operation_i) begin
            load_d = 1'b1;
            ovf_d  = pl_ovf;
            if (pl_fits) begin
              pat_we = 1'b1;
              len_d  = pl_base_len + LEN_W'(1);
            end else begin
              len_d  = pl_base_len;
            end
            if (last_i) begin
              load_d    = 1'b0;
              matched_d = '0;
              cnt_d     = '0;
              done_d    = 1'b0;
              if (pl_ovf) begin
                emit_v          = 1'b1;
                emit_res.status = ST_PAT_LONG;
              end else begin
                state_d = S_BINIT;
              end
            end
          end else if (!load_q) begin
            if (!done_q && cnt_q < CNT_W'(TEXT_MAX) && len_q != '0 && !ovf_q) begin
              sym_d      = symbol_i;
              last_d     = last_i;
              pat_raddr  = matched_q[PAT_AW-1:0];
              fail_raddr = matched_q[PAT_AW-1:0] - PAT_AW'(1);
              state_d    = S_TCMP;
            end else begin
              if (!done_q) begin
                if (cnt_q >= CNT_W'(TEXT_MAX)) begin
                  done_d          = 1'b1;
                  emit_v          = 1'b1;
                  emit_res.status = ST_TEXT_LONG;
                end else if (len_q == '0) begin
                  done_d            = 1'b1;
                  emit_v            = 1'b1;
                  emit_res.status   = ST_FOUND;
                  emit_res.position = pos_empty[POS_W-1:0];
                end else begin
                  cnt_d = cnt_q + CNT_W'(1);
                  if (last_i) begin
                    emit_v          = 1'b1;
                    emit_res.status = ST_NONE;
                  end
                end
              end
              if (last_i) begin
                matched_d = '0;
                cnt_d     = '0;
                done_d    = 1'b0;
              end
            end
          end
        end
      end
      S_BINIT: begin
        fail_we    = 1'b1;
        fail_waddr = '0;
        fail_wdata = '0;
        i_d        = LEN_W'(1);
        k_d        = '0;
        if (len_q == LEN_W'(1)) begin
          emit_v          = 1'b1;
          emit_res.status = ST_READY;
        end else begin
          pat_raddr = PAT_AW'(1);
          state_d   = S_BLOAD;
        end
      end
      S_BLOAD: begin
        byte_d     = pat_rdata_q;
        pat_raddr  = k_q[PAT_AW-1:0];
        fail_raddr = k_q[PAT_AW-1:0] - PAT_AW'(1);
        state_d    = S_BCMP;
      end
      S_BCMP: begin
        if (b_hit || k_q == '0) begin
          fail_we    = 1'b1;
          fail_waddr = i_q[PAT_AW-1:0];
          fail_wdata = b_knext[PAT_AW-1:0];
          k_d        = b_knext;
          i_d        = i_inc;
          if (i_inc == len_q) begin
            emit_v          = 1'b1;
            emit_res.status = ST_READY;
          end else begin
            pat_raddr = i_inc[PAT_AW-1:0];
            state_d   = S_BLOAD;
          end
        end else begin
          // follow the failure link
          k_d        = LEN_W'(fail_rdata_q);
          pat_raddr  = fail_rdata_q;
          fail_raddr = fail_rdata_q - PAT_AW'(1);
        end
      end
      S_TCMP: begin
        if (!t_hit && matched_q != '0) begin
          matched_d  = LEN_W'(fail_rdata_q);
          pat_raddr  = fail_rdata_q;
          fail_raddr = fail_rdata_q - PAT_AW'(1);
        end else begin
          matched_d = t_jnext;
          cnt_d     = cnt_q + CNT_W'(1);
          state_d   = S_IDLE;
          if (t_jnext == len_q) begin
            done_d            = 1'b1;
            emit_v            = 1'b1;
            emit_res.status   = ST_FOUND;
            emit_res.position = pos_found[POS_W-1:0];
          end else if (last_q) begin
            emit_v          = 1'b1;
            emit_res.status = ST_NONE;
          end
          if (last_q) begin
            matched_d = '0;
            cnt_d     = '0;
            done_d    = 1'b0;
          end
        end
      end
      S_OUT: begin
        emit_v   = 1'b1;
        emit_res = pend_q;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit_v) begin
      if (out_free) begin
        out_load = 1'b1;
        state_d  = S_IDLE;
      end else begin
        pend_d  = emit_res;
        state_d = S_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      load_q    <= 1'b0;
      matched_q <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      i_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      ovf_q     <= ovf_d;
      load_q    <= load_d;
      matched_q <= matched_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      i_q       <= i_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    pend_q <= pend_d;
  end

  kmp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (emit_res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (out_res),
    .free_o  (out_free)
  );

  assign status_o   = out_res.status;
  assign position_o = out_res.position;

  `KMP_ASSERT(a_tcmp_range, (state_q == S_TCMP) |-> (matched_q < len_q && !ovf_q && !load_q), "text step outside pattern")
  `KMP_ASSERT(a_build_order, (state_q == S_BCMP) |-> (k_q < i_q && i_q < len_q), "failure build index out of order")
  `KMP_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(TEXT_MAX), "text count past limit")
  `KMP_ASSERT_NEXT(a_pat_build, in_acc && !operation_i && last_i && !pl_ovf, state_q == S_BINIT, "pattern end did not start build")

endmodule
